// File: rtl/cra_pkg.sv
// ----------------------------------------------------------------------------
// Color ramp package
// Shared types and constants for the four-stop color ramp with alpha fade.
// ----------------------------------------------------------------------------
package cra_pkg;

  // Default fixed-point fraction width
  localparam int FRAC_BITS_DEF = 12;

  // Stop positions, warmth gain and minimum softness, in percent of one
  localparam int PCT_HOT  = 22;
  localparam int PCT_WARM = 58;
  localparam int PCT_EDGE = 82;
  localparam int PCT_KW   = 14;
  localparam int PCT_SMIN = 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SOFT_W     = 13;
  localparam int SOFT_RESET = 4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CORE_COLOR    = 3'd0,
    REG_HOT_COLOR     = 3'd1,
    REG_WARM_COLOR    = 3'd2,
    REG_EDGE_COLOR    = 3'd3,
    REG_EDGE_SOFTNESS = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [15:0] radius_in;
    logic signed [15:0] opacity_in;
    logic signed [15:0] warmth_in;
  } ramp_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } ramp_result_t;

endpackage

// File: rtl/color_ramp_alpha_fade.sv
// Throughput: one word per clock, on every clock where busy is low.
// The edge-fade quotient pipeline (one quotient bit per stage) sets the latency.
// Reset clears all valid bits, sets the colors to zero and the softness to one;
// busy stays high for one cycle after reset. The receiver cannot stall results.
// ----------------------------------------------------------------------------
// Color ramp with alpha fade
// Four-stop RGBA gradient picked by a warmth-shifted radius; alpha is scaled
// by opacity and by one minus a smoothstep fade near the outer radius.
// ----------------------------------------------------------------------------
module color_ramp_alpha_fade import cra_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  ramp_item_t            item,
  output logic                  done,
  output ramp_result_t          result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int F      = FRAC_BITS;
  localparam int ONE    = 1 << F;
  localparam longint ONE_SQ = longint'(1) << (2 * F);
  localparam int VW     = F + 1;
  localparam int S_HOT  = (PCT_HOT * ONE + 50) / 100;
  localparam int S_WARM = (PCT_WARM * ONE + 50) / 100;
  localparam int S_EDGE = (PCT_EDGE * ONE + 50) / 100;
  localparam int K_WARM = (PCT_KW * ONE + 50) / 100;
  localparam int S_MIN  = (PCT_SMIN * ONE + 50) / 100;
  localparam int DEN0   = S_HOT;
  localparam int DEN1   = S_WARM - S_HOT;
  localparam int DEN2   = S_EDGE - S_WARM;
  // Reciprocal multiply for the rounded blend quotient
  localparam int SH     = F + 10;
  localparam int MW     = 12;
  localparam int M0     = (1 << SH) / (2 * DEN0);
  localparam int M1     = (1 << SH) / (2 * DEN1);
  localparam int M2     = (1 << SH) / (2 * DEN2);
  localparam int KPW    = 2 * F + 2;
  localparam int NW     = F + 10;
  localparam int XW     = F + 9;
  localparam int PW     = XW + MW;
  localparam int QW     = 9;
  localparam int CW     = QW + F + 2;
  localparam int T2W    = 2 * F + 1;
  localparam int T3W    = 3 * F + 4;
  localparam int AFW    = F + 9;
  localparam int ALW    = 2 * F + 10;

  typedef enum logic [1:0] {
    SEG_CORE_HOT,
    SEG_HOT_WARM,
    SEG_WARM_EDGE
  } seg_t;

  function automatic logic [VW-1:0] clamp_unit(input logic signed [15:0] v);
    logic signed [31:0] x;
    x = 32'(v);
    if (x < 0) begin
      clamp_unit = '0;
    end else if (x > ONE) begin
      clamp_unit = VW'(ONE);
    end else begin
      clamp_unit = VW'(x);
    end
  endfunction

  function automatic logic [VW-1:0] den_of(input seg_t sg);
    case (sg)
      SEG_CORE_HOT: den_of = VW'(DEN0);
      SEG_HOT_WARM: den_of = VW'(DEN1);
      default:      den_of = VW'(DEN2);
    endcase
  endfunction

  function automatic logic [MW-1:0] recip_of(input seg_t sg);
    case (sg)
      SEG_CORE_HOT: recip_of = MW'(M0);
      SEG_HOT_WARM: recip_of = MW'(M1);
      default:      recip_of = MW'(M2);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Control and configuration
  // --------------------------------------------------------------------------
  logic [31:0]       core_color;
  logic [31:0]       hot_color;
  logic [31:0]       warm_color;
  logic [31:0]       edge_color;
  logic [SOFT_W-1:0] edge_softness;

  // Hold busy for one cycle out of reset
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  assign cfg_ready = !busy;

  // Write a configuration word; drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      core_color    <= '0;
      hot_color     <= '0;
      warm_color    <= '0;
      edge_color    <= '0;
      edge_softness <= SOFT_W'(SOFT_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CORE_COLOR:    core_color    <= cfg_data;
        REG_HOT_COLOR:     hot_color     <= cfg_data;
        REG_WARM_COLOR:    warm_color    <= cfg_data;
        REG_EDGE_COLOR:    edge_color    <= cfg_data;
        REG_EDGE_SOFTNESS: edge_softness <= cfg_data[SOFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp softness to its working range
  logic [31:0]   soft_ext;
  logic [VW-1:0] s_val;
  logic [VW:0]   d_val;

  always_comb begin
    soft_ext = 32'(edge_softness);
    if (soft_ext < 32'(S_MIN)) begin
      s_val = VW'(S_MIN);
    end else if (soft_ext > 32'(ONE)) begin
      s_val = VW'(ONE);
    end else begin
      s_val = VW'(soft_ext);
    end
    d_val = {s_val, 1'b0};
  end

  // --------------------------------------------------------------------------
  // Stage A: clamp inputs, scale warmth
  // --------------------------------------------------------------------------
  logic           a_valid;
  logic [VW-1:0]  a_r;
  logic [VW-1:0]  a_life;
  logic [KPW-1:0] a_kw;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= start && !busy;
    end
    a_r    <= clamp_unit(item.radius_in);
    a_life <= clamp_unit(item.opacity_in);
    a_kw   <= KPW'(K_WARM) * KPW'(clamp_unit(item.warmth_in));
  end

  // --------------------------------------------------------------------------
  // Stage B: warm radius and fade offset
  // --------------------------------------------------------------------------
  logic [KPW-1:0] kw_rnd;
  logic [VW:0]    wr_sum;
  logic [VW-1:0]  wr_c;
  logic [VW:0]    rs_sum;
  logic [VW-1:0]  u_c;

  always_comb begin
    kw_rnd = (a_kw + KPW'(ONE / 2)) >> F;
    wr_sum = (VW+1)'(a_r) + (VW+1)'(kw_rnd);
    if (wr_sum > (VW+1)'(ONE)) begin
      wr_c = VW'(ONE);
    end else begin
      wr_c = wr_sum[VW-1:0];
    end
    rs_sum = (VW+1)'(a_r) + (VW+1)'(s_val);
    if (rs_sum < (VW+1)'(ONE)) begin
      u_c = '0;
    end else begin
      u_c = VW'(rs_sum - (VW+1)'(ONE));
    end
  end

  // Quotient pipeline registers; index 0 is loaded by stage B
  logic          dv_valid [F+2];
  logic [VW-1:0] dv_rem   [F+1];
  logic [VW-1:0] dv_quo   [F+2];
  logic [VW-1:0] dv_wr    [F+2];
  logic [VW-1:0] dv_life  [F+2];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else begin
      dv_valid[0] <= a_valid;
    end
    dv_rem[0]  <= u_c;
    dv_quo[0]  <= '0;
    dv_wr[0]   <= wr_c;
    dv_life[0] <= a_life;
  end

  // --------------------------------------------------------------------------
  // Fade ratio t = round(u * ONE / s): one quotient bit per stage
  // --------------------------------------------------------------------------
  for (genvar k = 0; k <= F; k++) begin : g_div
    logic [VW:0] trial;
    logic        take;

    assign trial = {dv_rem[k], s_val[F-k]};
    assign take  = (trial >= d_val);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_valid[k+1] <= 1'b0;
      end else begin
        dv_valid[k+1] <= dv_valid[k];
      end
      dv_quo[k+1]  <= {dv_quo[k][VW-2:0], take};
      dv_wr[k+1]   <= dv_wr[k];
      dv_life[k+1] <= dv_life[k];
    end

    if (k < F) begin : g_rem
      always_ff @(posedge clk) begin
        if (take) begin
          dv_rem[k+1] <= VW'(trial - d_val);
        end else begin
          dv_rem[k+1] <= VW'(trial);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: pick segment, form blend numerators, square t
  // --------------------------------------------------------------------------
  seg_t                 seg_c;
  logic [31:0]          col_a;
  logic [31:0]          col_b;
  logic [VW-1:0]        lo_c;
  logic [VW-1:0]        pos_c;
  logic signed [8:0]    diff_c [4];
  logic signed [NW-1:0] dext_c [4];
  logic signed [NW-1:0] pext_c;
  logic signed [NW-1:0] num_c  [4];

  always_comb begin
    if (dv_wr[F+1] <= VW'(S_HOT)) begin
      seg_c = SEG_CORE_HOT;
      col_a = core_color;
      col_b = hot_color;
      lo_c  = '0;
    end else if (dv_wr[F+1] <= VW'(S_WARM)) begin
      seg_c = SEG_HOT_WARM;
      col_a = hot_color;
      col_b = warm_color;
      lo_c  = VW'(S_HOT);
    end else if (dv_wr[F+1] <= VW'(S_EDGE)) begin
      seg_c = SEG_WARM_EDGE;
      col_a = warm_color;
      col_b = edge_color;
      lo_c  = VW'(S_WARM);
    end else begin
      // Past the last stop: zero span gives the edge color as is
      seg_c = SEG_WARM_EDGE;
      col_a = edge_color;
      col_b = edge_color;
      lo_c  = dv_wr[F+1];
    end
    pos_c  = dv_wr[F+1] - lo_c;
    pext_c = NW'(pos_c);
    for (int i = 0; i < 4; i++) begin
      diff_c[i] = $signed({1'b0, col_b[8*i +: 8]}) - $signed({1'b0, col_a[8*i +: 8]});
      dext_c[i] = NW'(diff_c[i]);
      num_c[i]  = dext_c[i] * pext_c;
    end
  end

  logic                 s1_valid;
  seg_t                 s1_seg;
  logic [7:0]           s1_ca  [4];
  logic signed [NW-1:0] s1_num [4];
  logic [VW-1:0]        s1_t;
  logic [T2W-1:0]       s1_t2;
  logic [VW-1:0]        s1_life;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= dv_valid[F+1];
    end
    s1_seg  <= seg_c;
    for (int i = 0; i < 4; i++) begin
      s1_ca[i]  <= col_a[8*i +: 8];
      s1_num[i] <= num_c[i];
    end
    s1_t    <= dv_quo[F+1];
    s1_t2   <= T2W'(dv_quo[F+1]) * T2W'(dv_quo[F+1]);
    s1_life <= dv_life[F+1];
  end

  // --------------------------------------------------------------------------
  // Stage 2: magnitude plus half divisor; t^2 * (3 - 2t)
  // --------------------------------------------------------------------------
  logic [NW-1:0] mag_c [4];
  logic [VW:0]   kfac_c;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (s1_num[i] < 0) begin
        mag_c[i] = NW'(-s1_num[i]);
      end else begin
        mag_c[i] = NW'(s1_num[i]);
      end
    end
    kfac_c = (VW+1)'(3 * ONE) - {s1_t, 1'b0};
  end

  logic           s2_valid;
  seg_t           s2_seg;
  logic [7:0]     s2_ca  [4];
  logic           s2_neg [4];
  logic [XW-1:0]  s2_x   [4];
  logic [T3W-1:0] s2_t2k;
  logic [VW-1:0]  s2_life;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_seg <= s1_seg;
    for (int i = 0; i < 4; i++) begin
      s2_ca[i]  <= s1_ca[i];
      s2_neg[i] <= (s1_num[i] < 0);
      s2_x[i]   <= XW'({mag_c[i], 1'b0}) + XW'(den_of(s1_seg));
    end
    s2_t2k  <= T3W'(s1_t2) * T3W'(kfac_c);
    s2_life <= s1_life;
  end

  // --------------------------------------------------------------------------
  // Stage 3: reciprocal multiply; round smoothstep to the fade factor
  // --------------------------------------------------------------------------
  logic [T3W-1:0] sm_c;
  logic [VW-1:0]  fade_c;

  always_comb begin
    sm_c = (s2_t2k + T3W'(ONE_SQ / 2)) >> (2 * F);
    if (sm_c >= T3W'(ONE)) begin
      fade_c = '0;
    end else begin
      fade_c = VW'(T3W'(ONE) - sm_c);
    end
  end

  logic          s3_valid;
  seg_t          s3_seg;
  logic [7:0]    s3_ca   [4];
  logic          s3_neg  [4];
  logic [XW-1:0] s3_x    [4];
  logic [PW-1:0] s3_prod [4];
  logic [VW-1:0] s3_fade;
  logic [VW-1:0] s3_life;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_seg <= s2_seg;
    for (int i = 0; i < 4; i++) begin
      s3_ca[i]   <= s2_ca[i];
      s3_neg[i]  <= s2_neg[i];
      s3_x[i]    <= s2_x[i];
      s3_prod[i] <= PW'(s2_x[i]) * PW'(recip_of(s2_seg));
    end
    s3_fade <= fade_c;
    s3_life <= s2_life;
  end

  // --------------------------------------------------------------------------
  // Stage 4: quotient estimate, low by at most one
  // --------------------------------------------------------------------------
  logic          s4_valid;
  seg_t          s4_seg;
  logic [7:0]    s4_ca  [4];
  logic          s4_neg [4];
  logic [XW-1:0] s4_x   [4];
  logic [QW-1:0] s4_q0  [4];
  logic [VW-1:0] s4_fade;
  logic [VW-1:0] s4_life;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else begin
      s4_valid <= s3_valid;
    end
    s4_seg <= s3_seg;
    for (int i = 0; i < 4; i++) begin
      s4_ca[i]  <= s3_ca[i];
      s4_neg[i] <= s3_neg[i];
      s4_x[i]   <= s3_x[i];
      s4_q0[i]  <= QW'(s3_prod[i] >> SH);
    end
    s4_fade <= s3_fade;
    s4_life <= s3_life;
  end

  // --------------------------------------------------------------------------
  // Stage 5: multiply back the estimate
  // --------------------------------------------------------------------------
  logic          s5_valid;
  seg_t          s5_seg;
  logic [7:0]    s5_ca  [4];
  logic          s5_neg [4];
  logic [XW-1:0] s5_x   [4];
  logic [QW-1:0] s5_q0  [4];
  logic [CW-1:0] s5_chk [4];
  logic [VW-1:0] s5_fade;
  logic [VW-1:0] s5_life;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid <= 1'b0;
    end else begin
      s5_valid <= s4_valid;
    end
    s5_seg <= s4_seg;
    for (int i = 0; i < 4; i++) begin
      s5_ca[i]  <= s4_ca[i];
      s5_neg[i] <= s4_neg[i];
      s5_x[i]   <= s4_x[i];
      s5_q0[i]  <= s4_q0[i];
      s5_chk[i] <= CW'(s4_q0[i]) * CW'({den_of(s4_seg), 1'b0});
    end
    s5_fade <= s4_fade;
    s5_life <= s4_life;
  end

  // --------------------------------------------------------------------------
  // Stage 6: correct the quotient and apply it to the start color
  // --------------------------------------------------------------------------
  logic [CW-1:0]      rem_c [4];
  logic [QW:0]        q_c   [4];
  logic signed [10:0] v_c   [4];
  logic [7:0]         ch_c  [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rem_c[i] = CW'(s5_x[i]) - s5_chk[i];
      if (rem_c[i] >= CW'({den_of(s5_seg), 1'b0})) begin
        q_c[i] = (QW+1)'(s5_q0[i]) + (QW+1)'(1);
      end else begin
        q_c[i] = (QW+1)'(s5_q0[i]);
      end
      if (s5_neg[i]) begin
        v_c[i] = $signed({3'b000, s5_ca[i]}) - $signed({1'b0, q_c[i]});
      end else begin
        v_c[i] = $signed({3'b000, s5_ca[i]}) + $signed({1'b0, q_c[i]});
      end
      if (v_c[i] < 0) begin
        ch_c[i] = 8'd0;
      end else if (v_c[i] > 11'sd255) begin
        ch_c[i] = 8'd255;
      end else begin
        ch_c[i] = v_c[i][7:0];
      end
    end
  end

  logic          s6_valid;
  logic [7:0]    s6_ch [4];
  logic [VW-1:0] s6_fade;
  logic [VW-1:0] s6_life;

  always_ff @(posedge clk) begin
    if (rst) begin
      s6_valid <= 1'b0;
    end else begin
      s6_valid <= s5_valid;
    end
    for (int i = 0; i < 4; i++) begin
      s6_ch[i] <= ch_c[i];
    end
    s6_fade <= s5_fade;
    s6_life <= s5_life;
  end

  // --------------------------------------------------------------------------
  // Stages 7 and 8: alpha times fade, then times opacity
  // --------------------------------------------------------------------------
  logic           s7_valid;
  logic [7:0]     s7_rgb [3];
  logic [AFW-1:0] s7_af;
  logic [VW-1:0]  s7_life;

  always_ff @(posedge clk) begin
    if (rst) begin
      s7_valid <= 1'b0;
    end else begin
      s7_valid <= s6_valid;
    end
    for (int i = 0; i < 3; i++) begin
      s7_rgb[i] <= s6_ch[i];
    end
    s7_af   <= AFW'(s6_ch[3]) * AFW'(s6_fade);
    s7_life <= s6_life;
  end

  logic           s8_valid;
  logic [7:0]     s8_rgb [3];
  logic [ALW-1:0] s8_afl;

  always_ff @(posedge clk) begin
    if (rst) begin
      s8_valid <= 1'b0;
    end else begin
      s8_valid <= s7_valid;
    end
    for (int i = 0; i < 3; i++) begin
      s8_rgb[i] <= s7_rgb[i];
    end
    s8_afl <= ALW'(s7_af) * ALW'(s7_life);
  end

  // --------------------------------------------------------------------------
  // Stage 9: round alpha and present the result word
  // --------------------------------------------------------------------------
  logic [ALW-1:0] al_c;
  logic [7:0]     alpha_c;

  always_comb begin
    al_c = (s8_afl + ALW'(ONE_SQ / 2)) >> (2 * F);
    if (al_c > ALW'(255)) begin
      alpha_c = 8'd255;
    end else begin
      alpha_c = al_c[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s8_valid;
    end
    result.red   <= s8_rgb[0];
    result.green <= s8_rgb[1];
    result.blue  <= s8_rgb[2];
    result.alpha <= alpha_c;
  end

endmodule
